@@ sv/deque_with_rotate_unit_assert.svh @@
// Assertion macros used by the checker of the deque with rotate unit.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef DEQUE_WITH_ROTATE_UNIT_ASSERT_SVH
`define DEQUE_WITH_ROTATE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DQR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DQR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/dqr_pkg.sv @@
// Types, codes and pointer helpers of the deque with rotate unit.
// Depends on nothing; used by the control, the top level and the checker.
package dqr_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int MODE_W     = 3;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;

    localparam logic [MODE_W-1:0] M_PUSH_BACK  = 3'd0;
    localparam logic [MODE_W-1:0] M_PUSH_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] M_POP_BACK   = 3'd2;
    localparam logic [MODE_W-1:0] M_POP_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] M_ROTATE     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOOP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef logic [PTR_W-1:0]           t_ptr;
    typedef logic [CNT_W-1:0]           t_cnt;
    typedef logic [DATA_WIDTH-1:0]      t_data;
    typedef logic signed [VALUE_W-1:0]  t_value;
    typedef logic [COUNT_W-1:0]         t_count;
    typedef logic [STATUS_W-1:0]        t_status;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        t_value            value;
    } t_in_req;

    typedef struct packed {
        t_status status;
        t_count  count;
        t_value  front_value;
        t_value  back_value;
    } t_out_req;

    typedef struct packed {
        logic  wr_en;
        t_ptr  wr_addr;
        t_data wr_data;
        t_ptr  rd_addr_front;
        t_ptr  rd_addr_back;
    } t_mem_req;

    typedef struct packed {
        t_status status;
        t_cnt    count;
    } t_op_res;

    // Ring index p + off, with off no larger than DEPTH.
    function automatic t_ptr ptr_add(t_ptr p, t_cnt off);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(p) + (CNT_W + 1)'(off);
        if (s >= (CNT_W + 1)'(DEPTH)) begin
            s = s - (CNT_W + 1)'(DEPTH);
        end
        return t_ptr'(s);
    endfunction

    function automatic t_ptr ptr_dec(t_ptr p);
        return (p == '0) ? t_ptr'(DEPTH - 1) : p - t_ptr'(1);
    endfunction

    // Stored element to the 32-bit signed result field.
    function automatic t_value to_value(t_data d);
        logic signed [DATA_WIDTH-1:0] s;
        s = d;
        return t_value'(s);
    endfunction

endpackage

@@ sv/deque_with_rotate_unit.sv @@
// Deque with rotate: a bounded double-ended queue of DATA_WIDTH-bit signed elements
// (DEPTH entries) in a ring RAM. Each request is one operation: push back, push front,
// pop back, pop front, or rotate (front element moves to the back). One operation is
// accepted per clock cycle while o_stall is low, and its result request appears in the
// cycle after acceptance through the registered read of the element RAM, whose two read
// ports fetch the new front and back elements while the single write port stores a
// pushed or rotated element. The result reports the status, the new count and the front
// and back values (zero when empty). The element RAM needs no clearing after reset. A
// result that is stalled holds the output register, and o_stall then holds off new
// requests. Depends on dqr_pkg, dqr_ctrl and dqr_ram.
module deque_with_rotate_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  dqr_pkg::t_in_req  i_req,
    output logic              o_valid,
    input  logic              i_stall,
    output dqr_pkg::t_out_req o_req
);

    logic              s_accept;
    dqr_pkg::t_mem_req s_mem;
    dqr_pkg::t_op_res  s_res;
    dqr_pkg::t_data    s_rd_front;
    dqr_pkg::t_data    s_rd_back;
    dqr_pkg::t_data    s_front;
    dqr_pkg::t_data    s_back;

    // Output stage, loaded on every accepted request and held otherwise.
    logic              r_out_valid;
    logic              n_out_valid;
    dqr_pkg::t_status  r_status;
    dqr_pkg::t_cnt     r_count;
    logic              r_byp_front;
    logic              r_byp_back;
    dqr_pkg::t_data    r_wr_data;

    // A new request enters whenever the output register is free or being drained.
    assign o_stall  = r_out_valid & i_stall;
    assign s_accept = i_valid & ~o_stall;

    dqr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (s_accept),
        .i_req       (i_req),
        .i_cur_front (s_front),
        .o_mem       (s_mem),
        .o_res       (s_res)
    );

    dqr_ram #(
        .WIDTH (dqr_pkg::DATA_WIDTH),
        .DEPTH (dqr_pkg::DEPTH)
    ) u_ram (
        .i_clk (i_clk),
        .i_we  (s_accept & s_mem.wr_en),
        .i_wa  (s_mem.wr_addr),
        .i_wd  (s_mem.wr_data),
        .i_re  (s_accept),
        .i_ra0 (s_mem.rd_addr_front),
        .i_ra1 (s_mem.rd_addr_back),
        .o_rd0 (s_rd_front),
        .o_rd1 (s_rd_back)
    );

    // The RAM returns old data when the same entry is written in the read cycle, so
    // the written element is forwarded in that case.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_status    <= s_res.status;
            r_count     <= s_res.count;
            r_byp_front <= s_mem.wr_en && (s_mem.wr_addr == s_mem.rd_addr_front);
            r_byp_back  <= s_mem.wr_en && (s_mem.wr_addr == s_mem.rd_addr_back);
            r_wr_data   <= s_mem.wr_data;
        end
    end

    assign s_front = r_byp_front ? r_wr_data : s_rd_front;
    assign s_back  = r_byp_back  ? r_wr_data : s_rd_back;

    always_comb begin
        n_out_valid = r_out_valid;
        if (s_accept) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_req.status      = r_status;
    assign o_req.count       = dqr_pkg::t_count'(r_count);
    assign o_req.front_value = (r_count == '0) ? '0 : dqr_pkg::to_value(s_front);
    assign o_req.back_value  = (r_count == '0) ? '0 : dqr_pkg::to_value(s_back);

endmodule

@@ sv/dqr_ram.sv @@
// Generic RAM: one write port and two read ports with registered read data.
// Depends on nothing.
module dqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wa,
    input  logic [WIDTH-1:0]         i_wd,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_ra0,
    input  logic [$clog2(DEPTH)-1:0] i_ra1,
    output logic [WIDTH-1:0]         o_rd0,
    output logic [WIDTH-1:0]         o_rd1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Reads return the contents from before a write in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            o_rd0 <= r_mem[i_ra0];
            o_rd1 <= r_mem[i_ra1];
        end
    end

endmodule

@@ sv/dqr_ctrl.sv @@
// Pointer and count control of the deque with rotate unit.
// Depends on dqr_pkg; decodes one operation and drives the element RAM ports.
module dqr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  dqr_pkg::t_in_req  i_req,
    input  dqr_pkg::t_data    i_cur_front,
    output dqr_pkg::t_mem_req o_mem,
    output dqr_pkg::t_op_res  o_res
);

    dqr_pkg::t_ptr r_fp;
    dqr_pkg::t_cnt r_cnt;
    dqr_pkg::t_ptr n_fp;
    dqr_pkg::t_cnt n_cnt;
    logic          s_full;
    logic          s_empty;

    assign s_full  = (r_cnt == dqr_pkg::t_cnt'(dqr_pkg::DEPTH));
    assign s_empty = (r_cnt == '0);

    always_comb begin
        n_fp          = r_fp;
        n_cnt         = r_cnt;
        o_res.status  = dqr_pkg::ST_DONE;
        o_mem.wr_en   = 1'b0;
        o_mem.wr_addr = dqr_pkg::ptr_add(r_fp, r_cnt);
        o_mem.wr_data = dqr_pkg::t_data'(i_req.value);
        unique case (i_req.mode)
            dqr_pkg::M_PUSH_BACK: begin
                if (s_full) begin
                    o_res.status = dqr_pkg::ST_FULL;
                end else begin
                    o_mem.wr_en = 1'b1;
                    n_cnt       = r_cnt + dqr_pkg::t_cnt'(1);
                end
            end
            dqr_pkg::M_PUSH_FRONT: begin
                if (s_full) begin
                    o_res.status = dqr_pkg::ST_FULL;
                end else begin
                    n_fp          = dqr_pkg::ptr_dec(r_fp);
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = n_fp;
                    n_cnt         = r_cnt + dqr_pkg::t_cnt'(1);
                end
            end
            dqr_pkg::M_POP_BACK: begin
                if (s_empty) begin
                    o_res.status = dqr_pkg::ST_NOOP;
                end else begin
                    n_cnt = r_cnt - dqr_pkg::t_cnt'(1);
                end
            end
            dqr_pkg::M_POP_FRONT: begin
                if (s_empty) begin
                    o_res.status = dqr_pkg::ST_NOOP;
                end else begin
                    n_fp  = dqr_pkg::ptr_add(r_fp, dqr_pkg::t_cnt'(1));
                    n_cnt = r_cnt - dqr_pkg::t_cnt'(1);
                end
            end
            dqr_pkg::M_ROTATE: begin
                if (r_cnt < dqr_pkg::t_cnt'(2)) begin
                    o_res.status = dqr_pkg::ST_NOOP;
                end else begin
                    // When full, the slot after the back is the front slot itself.
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_data = i_cur_front;
                    n_fp          = dqr_pkg::ptr_add(r_fp, dqr_pkg::t_cnt'(1));
                end
            end
            default: begin
                o_res.status = dqr_pkg::ST_NOOP;
            end
        endcase
        o_res.count         = n_cnt;
        o_mem.rd_addr_front = n_fp;
        o_mem.rd_addr_back  = dqr_pkg::ptr_add(n_fp,
                                  (n_cnt == '0) ? '0 : n_cnt - dqr_pkg::t_cnt'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fp  <= '0;
            r_cnt <= '0;
        end else if (i_accept) begin
            r_fp  <= n_fp;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ sv/dqr_checker.sv @@
// Port-level assertions of the deque with rotate unit, bound to the top level.
// Depends on dqr_pkg and deque_with_rotate_unit_assert.svh.
`include "deque_with_rotate_unit_assert.svh"

module dqr_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input dqr_pkg::t_in_req  i_req,
    input logic              o_valid,
    input logic              i_stall,
    input dqr_pkg::t_out_req o_req
);

    // A stalled result must stay put.
    `DQR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_req), "stalled result changed")

    // Every accepted request yields a result in the next cycle.
    `DQR_ASSERT_NEXT(a_result, i_clk, i_rst_n, i_valid && !o_stall, o_valid, "accepted request gave no result")

    // The count never exceeds the capacity.
    `DQR_ASSERT_SAME(a_count, i_clk, i_rst_n, o_valid, 32'(o_req.count) <= dqr_pkg::DEPTH, "count above capacity")

    // An empty queue shows zero front and back values.
    `DQR_ASSERT_SAME(a_empty, i_clk, i_rst_n, o_valid && (o_req.count == '0), (o_req.front_value == '0) && (o_req.back_value == '0), "empty queue shows values")

    // A dropped push is reported only on a full queue.
    `DQR_ASSERT_SAME(a_full, i_clk, i_rst_n, o_valid && (o_req.status == dqr_pkg::ST_FULL), o_req.count == dqr_pkg::t_count'(dqr_pkg::DEPTH), "full status without full queue")

endmodule

bind deque_with_rotate_unit dqr_checker u_dqr_checker (.*);
